FILE: sv/assert_macros.svh
// assertion helper macros for the marker segment filter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, off while reset is low
`define JMS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// condition that must never be seen
`define JMS_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

FILE: sv/jms_pkg.sv
// shared types, codes and tables of the marker segment filter
`default_nettype none
package jms_pkg;

  localparam int unsigned MaxFill = 15;
  localparam int unsigned QDepth  = 4;

  localparam logic [7:0] BYTE_FF   = 8'hff;
  localparam logic [7:0] MRK_SOI   = 8'hd8;
  localparam logic [7:0] MRK_EOI   = 8'hd9;
  localparam logic [7:0] MRK_SOS   = 8'hda;
  localparam logic [7:0] MRK_DNL   = 8'hdc;
  localparam logic [7:0] MRK_APP0  = 8'he0;
  localparam logic [7:0] MRK_APP2  = 8'he2;
  localparam logic [7:0] MRK_APP14 = 8'hee;
  localparam logic [7:0] MRK_APP15 = 8'hef;
  localparam logic [7:0] MRK_COM   = 8'hfe;
  localparam logic [7:0] MRK_RST0  = 8'hd0;
  localparam logic [7:0] MRK_RST7  = 8'hd7;
  localparam logic [7:0] MRK_TEM   = 8'h01;

  localparam logic [1:0] ST_DATA = 2'd0;
  localparam logic [1:0] ST_EOI  = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_file;
  } jms_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       run_last;
  } jms_out_t;

  typedef enum logic [2:0] {
    KIND_COPY  = 3'd0,
    KIND_DROP  = 3'd1,
    KIND_JFIF  = 3'd2,
    KIND_ADOBE = 3'd3,
    KIND_ICC   = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    BODY_NONE = 2'd0,
    BODY_JFIF = 2'd1,
    BODY_PFX  = 2'd2
  } body_e;

  // one burst of output beats, as decided by the parser
  typedef struct packed {
    logic            err;
    logic            eoi;
    logic [4:0]      ffn;
    logic [1:0]      nb;
    logic [2:0][7:0] hdr;
    body_e           body;
    logic [11:0][7:0] pfx;
  } jms_cmd_t;

  function automatic logic [7:0] sig_byte(input kind_e k, input logic [3:0] i);
    logic [7:0] r;
    r = 8'h00;
    case (k)
      KIND_JFIF: begin
        case (i)
          4'd0: r = 8'h4a; 4'd1: r = 8'h46; 4'd2: r = 8'h49; 4'd3: r = 8'h46;
          default: r = 8'h00;
        endcase
      end
      KIND_ADOBE: begin
        case (i)
          4'd0: r = 8'h41; 4'd1: r = 8'h64; 4'd2: r = 8'h6f; 4'd3: r = 8'h62;
          4'd4: r = 8'h65;
          default: r = 8'h00;
        endcase
      end
      default: begin
        case (i)
          4'd0: r = 8'h49; 4'd1: r = 8'h43; 4'd2: r = 8'h43; 4'd3: r = 8'h5f;
          4'd4: r = 8'h50; 4'd5: r = 8'h52; 4'd6: r = 8'h4f; 4'd7: r = 8'h46;
          4'd8: r = 8'h49; 4'd9: r = 8'h4c; 4'd10: r = 8'h45;
          default: r = 8'h00;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic sig_match(input kind_e k, input logic [11:0][7:0] buf_v);
    logic ok;
    logic [3:0] slen;
    ok = 1'b1;
    slen = (k == KIND_ICC) ? 4'd12 : 4'd5;
    for (int i = 0; i < 12; i++) begin
      if (4'(i) < slen && buf_v[i] != sig_byte(k, 4'(i))) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic logic [7:0] jfif_tail(input logic [2:0] i);
    logic [7:0] r;
    r = 8'h00;
    case (i)
      3'd2, 3'd4: r = 8'h01;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/jpeg_metadata_stripper.sv
// top level of the jpeg metadata stripper
//
//  channel    | direction | handshake                    | beat
//  -----------+-----------+------------------------------+-----------------------------
//  in         | in        | in_valid_i / in_stall_o      | one file byte, eof flag
//  out        | out       | out_valid_o / out_stall_i    | cleaned byte, status, run_last
//  config     | in        | preserve_icc_we_i            | preserve_icc bit
//
// one input beat is taken per cycle while the burst queue has room; a beat expands
// into 0 to 19 output beats, sent one per cycle by the emitter unless stalled, so
// the output side sets the sustained rate whenever bursts run longer than one beat
// the input stalls only when the four-entry burst queue is full
// reset puts the parser at the start of file and preserve_icc at 1; no clearing pass
// after end of image or an error, input beats are taken and dropped until reset
`default_nettype none
module jpeg_metadata_stripper
  import jms_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire jms_in_t  in_data_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output jms_out_t      out_data_o,
  input  wire logic     preserve_icc_we_i,
  input  wire logic     preserve_icc_i
);

  // config register
  logic preserve_icc_q;

  // front to queue
  logic     push, acc;
  jms_cmd_t cmd;

  // queue to back
  logic     full, empty, pop;
  jms_cmd_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preserve_icc_q <= 1'b1;
    end else if (preserve_icc_we_i) begin
      preserve_icc_q <= preserve_icc_i;
    end
  end

  // accept whenever the queue can take a burst
  assign in_stall_o = full;
  assign acc = in_valid_i && !full;

  jms_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .acc_i          (acc),
    .in_i           (in_data_i),
    .preserve_icc_i (preserve_icc_q),
    .push_o         (push),
    .cmd_o          (cmd)
  );

  jms_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  // emitter owns the output register
  jms_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_data_o)
  );

endmodule
`default_nettype wire

FILE: sv/jms_front.sv
// parser: takes input beats, tracks marker structure, issues output bursts
`default_nettype none
module jms_front
  import jms_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     acc_i,
  input  wire jms_in_t  in_i,
  input  wire logic     preserve_icc_i,
  output logic          push_o,
  output jms_cmd_t      cmd_o
);

`include "assert_macros.svh"

  typedef enum logic [10:0] {
    PH_SOI0    = 11'b00000000001,
    PH_SOI1    = 11'b00000000010,
    PH_MARK    = 11'b00000000100,
    PH_FILL    = 11'b00000001000,
    PH_LENHI   = 11'b00000010000,
    PH_LENLO   = 11'b00000100000,
    PH_PAYLOAD = 11'b00001000000,
    PH_ENTROPY = 11'b00010000000,
    PH_EFF     = 11'b00100000000,
    PH_DONE    = 11'b01000000000,
    PH_ERR     = 11'b10000000000
  } phase_e;

  phase_e phase_q, phase_d;
  logic [3:0] fill_q, fill_d;
  logic [7:0] marker_q, marker_d;
  logic [15:0] rem_q, rem_d;
  kind_e kind_q, kind_d;
  logic [3:0] pc_q, pc_d;
  logic seen_q, seen_d;
  logic [11:0][7:0] pfx_q;
  logic [11:0][7:0] snap;
  logic pfx_we;

  logic [7:0] b;
  logic [15:0] rem_m1, len16;
  logic [3:0] pc_inc;
  logic [16:0] total, need, cap, req;
  logic [3:0] slen;
  logic decide, sig_ok;
  logic failed, emit;
  logic recog;

  assign b = in_i.data_byte;
  assign rem_m1 = rem_q - 16'd1;
  assign pc_inc = (pc_q < 4'd12) ? pc_q + 4'd1 : pc_q;
  assign total = {1'b0, rem_m1} + 17'(pc_inc);
  assign cap = (kind_q == KIND_JFIF) ? 17'd7 : 17'd12;
  assign need = (total < cap) ? total : cap;
  assign decide = 17'(pc_inc) >= need;
  assign slen = (kind_q == KIND_ICC) ? 4'd12 : 4'd5;
  assign req = (kind_q == KIND_ADOBE) ? 17'd12 : 17'd14;
  assign len16 = total[15:0] + 16'd2;
  assign recog = (kind_q == KIND_JFIF) || (kind_q == KIND_ADOBE) || (kind_q == KIND_ICC);

  always_comb begin
    for (int i = 0; i < 12; i++) begin
      snap[i] = (pc_q == 4'(i)) ? b : pfx_q[i];
    end
  end
  assign sig_ok = (pc_inc >= slen) && sig_match(kind_q, snap);

  always_comb begin
    phase_d  = phase_q;
    fill_d   = fill_q;
    marker_d = marker_q;
    rem_d    = rem_q;
    kind_d   = kind_q;
    pc_d     = pc_q;
    seen_d   = seen_q;
    failed   = 1'b0;
    emit     = 1'b0;
    pfx_we   = 1'b0;
    cmd_o      = '0;
    cmd_o.pfx  = snap;
    cmd_o.body = BODY_NONE;
    if (acc_i) begin
      unique case (phase_q)
        PH_SOI0: begin
          if (b == BYTE_FF) phase_d = PH_SOI1;
          else failed = 1'b1;
        end
        PH_SOI1: begin
          if (b == MRK_SOI) begin
            emit = 1'b1;
            cmd_o.ffn = 5'd1;
            cmd_o.nb = 2'd1;
            cmd_o.hdr[0] = MRK_SOI;
            phase_d = PH_MARK;
          end else failed = 1'b1;
        end
        PH_MARK: begin
          if (b == BYTE_FF) begin
            fill_d = '0;
            phase_d = PH_FILL;
          end else failed = 1'b1;
        end
        PH_FILL, PH_EFF: begin
          if (b == BYTE_FF) begin
            if (32'(fill_q) >= MaxFill) failed = 1'b1;
            else fill_d = fill_q + 4'd1;
          end else if (phase_q == PH_EFF && (b == 8'h00 || b == MRK_TEM ||
                       (b >= MRK_RST0 && b <= MRK_RST7))) begin
            emit = 1'b1;
            cmd_o.ffn = 5'(fill_q) + 5'd1;
            cmd_o.nb = 2'd1;
            cmd_o.hdr[0] = b;
            phase_d = PH_ENTROPY;
          end else if (b == 8'h00 || b == MRK_SOI) begin
            failed = 1'b1;
          end else if (b == MRK_EOI) begin
            if (!seen_q) failed = 1'b1;
            else begin
              emit = 1'b1;
              cmd_o.eoi = 1'b1;
              cmd_o.ffn = 5'd1;
              cmd_o.nb = 2'd1;
              cmd_o.hdr[0] = MRK_EOI;
              phase_d = PH_DONE;
            end
          end else if (b == MRK_TEM || (b >= MRK_RST0 && b <= MRK_RST7)) begin
            emit = 1'b1;
            cmd_o.ffn = 5'(fill_q) + 5'd1;
            cmd_o.nb = 2'd1;
            cmd_o.hdr[0] = b;
            phase_d = PH_MARK;
          end else begin
            marker_d = b;
            phase_d = PH_LENHI;
          end
        end
        PH_LENHI: begin
          rem_d = {8'h00, b};
          phase_d = PH_LENLO;
        end
        PH_LENLO: begin
          if ({rem_q[7:0], b} < 16'd2) failed = 1'b1;
          else begin
            rem_d = {rem_q[7:0], b} - 16'd2;
            pc_d = '0;
            phase_d = PH_PAYLOAD;
            if (marker_q == MRK_APP0) kind_d = KIND_JFIF;
            else if (marker_q == MRK_APP14) kind_d = KIND_ADOBE;
            else if (marker_q == MRK_APP2 && preserve_icc_i) kind_d = KIND_ICC;
            else if ((marker_q >= MRK_APP0 && marker_q <= MRK_APP15) || marker_q == MRK_COM)
              kind_d = KIND_DROP;
            else begin
              kind_d = KIND_COPY;
              emit = 1'b1;
              cmd_o.ffn = 5'(fill_q) + 5'd1;
              cmd_o.nb = 2'd3;
              cmd_o.hdr[0] = marker_q;
              cmd_o.hdr[1] = rem_q[7:0];
              cmd_o.hdr[2] = b;
            end
            if (rem_d == 16'd0) begin
              if (marker_q == MRK_SOS || (marker_q == MRK_DNL && seen_q)) begin
                seen_d = 1'b1;
                phase_d = PH_ENTROPY;
              end else phase_d = PH_MARK;
            end
          end
        end
        PH_PAYLOAD: begin
          rem_d = rem_m1;
          if (kind_q == KIND_COPY) begin
            emit = 1'b1;
            cmd_o.nb = 2'd1;
            cmd_o.hdr[0] = b;
          end else if (recog) begin
            pfx_we = pc_q < 4'd12;
            pc_d = pc_inc;
            if (decide) begin
              if (!sig_ok) kind_d = KIND_DROP;
              else if (total < req) failed = 1'b1;
              else begin
                emit = 1'b1;
                cmd_o.ffn = 5'd1;
                cmd_o.nb = 2'd3;
                cmd_o.hdr[0] = marker_q;
                if (kind_q == KIND_JFIF) begin
                  cmd_o.hdr[1] = 8'h00;
                  cmd_o.hdr[2] = 8'h10;
                  cmd_o.body = BODY_JFIF;
                  kind_d = KIND_DROP;
                end else if (kind_q == KIND_ADOBE) begin
                  cmd_o.hdr[1] = 8'h00;
                  cmd_o.hdr[2] = 8'h0e;
                  cmd_o.body = BODY_PFX;
                  kind_d = KIND_DROP;
                end else begin
                  cmd_o.hdr[1] = len16[15:8];
                  cmd_o.hdr[2] = len16[7:0];
                  cmd_o.body = BODY_PFX;
                  kind_d = KIND_COPY;
                end
              end
            end
          end
          if (!failed && rem_m1 == 16'd0) begin
            if (marker_q == MRK_SOS || (marker_q == MRK_DNL && seen_q)) begin
              seen_d = 1'b1;
              phase_d = PH_ENTROPY;
            end else phase_d = PH_MARK;
          end
        end
        PH_ENTROPY: begin
          if (b != BYTE_FF) begin
            emit = 1'b1;
            cmd_o.nb = 2'd1;
            cmd_o.hdr[0] = b;
          end else begin
            fill_d = '0;
            phase_d = PH_EFF;
          end
        end
        PH_DONE, PH_ERR: begin
        end
        default: failed = 1'b1;
      endcase
      // truncated file
      if (!failed && in_i.end_of_file && phase_d != PH_DONE && phase_q != PH_DONE &&
          phase_q != PH_ERR) failed = 1'b1;
      if (failed) phase_d = PH_ERR;
    end
    cmd_o.err = failed;
    push_o = acc_i && (failed || emit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SOI0;
      fill_q   <= '0;
      marker_q <= '0;
      rem_q    <= '0;
      kind_q   <= KIND_COPY;
      pc_q     <= '0;
      seen_q   <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fill_q   <= fill_d;
      marker_q <= marker_d;
      rem_q    <= rem_d;
      kind_q   <= kind_d;
      pc_q     <= pc_d;
      seen_q   <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pfx_we) pfx_q <= snap;
  end

  `JMS_ASSERT(a_quiet_after_end, clk_i, rst_ni,
              (phase_q == PH_DONE || phase_q == PH_ERR) |-> !push_o,
              "burst issued after end of stream")
  `JMS_ASSERT(a_err_alone, clk_i, rst_ni,
              (push_o && cmd_o.err) |=> (phase_q == PH_ERR),
              "error burst without error state")

endmodule
`default_nettype wire

FILE: sv/jms_queue.sv
// short burst command queue between parser and emitter
`default_nettype none
module jms_queue
  import jms_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire jms_cmd_t cmd_i,
  input  wire logic     pop_i,
  output logic          full_o,
  output logic          empty_o,
  output jms_cmd_t      head_o
);

`include "assert_macros.svh"

  localparam int unsigned AW = $clog2(QDepth);

  jms_cmd_t mem_q [QDepth];
  logic [AW-1:0] wp_q, rp_q;
  logic [AW:0] cnt_q;

  assign full_o  = cnt_q == (AW+1)'(QDepth);
  assign empty_o = cnt_q == '0;
  assign head_o  = mem_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i) rp_q <= rp_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= cmd_i;
  end

  `JMS_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `JMS_NEVER(a_no_underflow, clk_i, rst_ni, pop_i && empty_o, "pop from empty queue")

endmodule
`default_nettype wire

FILE: sv/jms_back.sv
// emitter: expands burst commands into output beats through an output register
`default_nettype none
module jms_back
  import jms_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     empty_i,
  input  wire jms_cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output jms_out_t      out_o
);

`include "assert_macros.svh"

  logic [4:0] pos_q, pos_d;
  logic       vld_q;
  jms_out_t   out_q, beat;
  logic [4:0] blen, len, q, r;
  logic       last, load;

  always_comb begin
    case (head_i.body)
      BODY_JFIF: blen = 5'd14;
      BODY_PFX:  blen = 5'd12;
      default:   blen = 5'd0;
    endcase
  end

  assign len  = head_i.err ? 5'd1 : head_i.ffn + 5'(head_i.nb) + blen;
  assign last = pos_q == len - 5'd1;
  assign q    = pos_q - head_i.ffn;
  assign r    = q - 5'(head_i.nb);
  assign load = !empty_i && (!vld_q || !out_stall_i);
  assign pop_o = load && last;

  always_comb begin
    beat = '0;
    beat.run_last = last;
    if (head_i.err) beat.status = ST_ERR;
    else begin
      beat.status = (last && head_i.eoi) ? ST_EOI : ST_DATA;
      if (pos_q < head_i.ffn) beat.out_byte = BYTE_FF;
      else if (q < 5'(head_i.nb)) beat.out_byte = head_i.hdr[q[1:0]];
      else if (head_i.body == BODY_JFIF && r >= 5'd7) beat.out_byte = jfif_tail(3'(r - 5'd7));
      else beat.out_byte = head_i.pfx[r[3:0]];
    end
  end

  assign pos_d = last ? 5'd0 : pos_q + 5'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      vld_q <= 1'b0;
    end else begin
      if (load) pos_q <= pos_d;
      if (load) vld_q <= 1'b1;
      else if (!out_stall_i) vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_q <= beat;
  end

  assign out_valid_o = vld_q;
  assign out_o = out_q;

  `JMS_ASSERT(a_err_is_last, clk_i, rst_ni,
              (vld_q && out_q.status == ST_ERR) |-> out_q.run_last,
              "error beat not last of its run")
  `JMS_ASSERT(a_eoi_is_last, clk_i, rst_ni,
              (vld_q && out_q.status == ST_EOI) |-> (out_q.run_last && out_q.out_byte == MRK_EOI),
              "bad end of image beat")

endmodule
`default_nettype wire

FILE: tb/sv/tb_jpeg_metadata_stripper.sv
// self-checking testbench of the jpeg metadata stripper
`default_nettype none
module tb_jpeg_metadata_stripper;
  import jms_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // parser phases of the scoreboard's own copy of the filter
  typedef enum int {
    P_SOI0, P_SOI1, P_MARK, P_FILL, P_LENHI, P_LENLO,
    P_BODY, P_SCAN, P_SCANFF, P_DONE, P_ERR
  } phase_e;

  // one row of the directed table; typed rows carry their results inline
  typedef struct {
    logic [7:0] b;
    bit         typed;
    int         n;
    jms_out_t   e0;
    jms_out_t   e1;
  } dir_row_t;

  // segment signatures, left aligned, first byte in the top bits
  localparam logic [95:0] SIG_JFIF  = {40'h4a46494600, 56'h0};
  localparam logic [95:0] SIG_ADOBE = {40'h41646f6265, 56'h0};
  localparam logic [95:0] SIG_ICC   = 96'h4943435f50524f46494c4500;
  localparam jms_out_t    NO_BEAT   = '0;
  localparam int          HOLD_CYC  = 60;
  localparam int          DRAIN_CYC = 12;
  localparam int          WDOG_MAX  = 3000;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  jms_in_t  in_data_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  jms_out_t out_data_o;
  logic     preserve_icc_we_i = 1'b0;
  logic     preserve_icc_i = 1'b0;

  jpeg_metadata_stripper DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .in_data_i         (in_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_data_o        (out_data_o),
    .preserve_icc_we_i (preserve_icc_we_i),
    .preserve_icc_i    (preserve_icc_i)
  );

  always #5 clk_i = ~clk_i;

  // scoreboard copy of the filter state
  phase_e     ph;
  logic [4:0] fills;
  logic [7:0] mark;
  logic [15:0] rem;
  kind_e      kind;
  logic [7:0] pfx [12];
  logic [3:0] pcnt;
  bit         scan_seen;
  bit         keep_icc;

  jms_out_t clean_q [$];   // cleaned-stream beats still owed by the block
  jms_out_t burst [$];     // beats caused by the byte being modeled

  // typed expectations travel with the beat on the wire
  bit       row_typed, lat_typed;
  int       row_n, lat_n;
  jms_out_t row_e [2];
  jms_out_t lat_e [2];

  bit calm;        // no idling on either side near the end
  bit hold_go;     // asks the receiver for one long hold-off
  int n_in, n_out, n_bad, n_sent, n_cfg;
  string end_kind;
  dir_row_t dir_tab [21];
  logic [7:0] body_q [$];

  // ---------------------------------------------------------------------------
  // filter model
  // ---------------------------------------------------------------------------
  function automatic void put(input logic [7:0] b, input logic [1:0] st);
    jms_out_t o;
    o.out_byte = b;
    o.status   = st;
    o.run_last = 1'b0;
    burst.push_back(o);
  endfunction

  // ff plus any fill bytes that came in front of the marker
  function automatic void put_ff_run();
    put(BYTE_FF, ST_DATA);
    for (int i = 0; i < fills; i++) put(BYTE_FF, ST_DATA);
  endfunction

  function automatic void seg_end();
    if (mark == MRK_SOS || (mark == MRK_DNL && scan_seen)) begin
      scan_seen = 1'b1;
      ph = P_SCAN;
    end else begin
      ph = P_MARK;
    end
  endfunction

  // decide a recognized segment once enough of its payload has been buffered
  function automatic void decide(inout bit bad);
    int total, cap, need, slen, req, len;
    logic [95:0] sig;
    bit ok;
    total = int'(rem) + int'(pcnt);
    cap   = (kind == KIND_JFIF) ? 7 : 12;
    need  = (total < cap) ? total : cap;
    if (int'(pcnt) < need) return;
    case (kind)
      KIND_JFIF:  begin sig = SIG_JFIF;  slen = 5;  req = 14; end
      KIND_ADOBE: begin sig = SIG_ADOBE; slen = 5;  req = 12; end
      default:    begin sig = SIG_ICC;   slen = 12; req = 14; end
    endcase
    ok = (int'(pcnt) >= slen);
    for (int i = 0; i < slen; i++)
      if (ok && pfx[i] != sig[95-8*i -: 8]) ok = 1'b0;
    if (!ok) begin
      kind = KIND_DROP;
      return;
    end
    if (total < req) begin
      bad = 1'b1;
      return;
    end
    put(BYTE_FF, ST_DATA);
    put(mark, ST_DATA);
    if (kind == KIND_JFIF) begin
      // density forced to 1:1, thumbnail size zero
      put(8'h00, ST_DATA);
      put(8'h10, ST_DATA);
      for (int i = 0; i < 7; i++) put(pfx[i], ST_DATA);
      put(8'h00, ST_DATA); put(8'h00, ST_DATA); put(8'h01, ST_DATA);
      put(8'h00, ST_DATA); put(8'h01, ST_DATA); put(8'h00, ST_DATA);
      put(8'h00, ST_DATA);
      kind = KIND_DROP;
    end else if (kind == KIND_ADOBE) begin
      put(8'h00, ST_DATA);
      put(8'h0e, ST_DATA);
      for (int i = 0; i < 12; i++) put(pfx[i], ST_DATA);
      kind = KIND_DROP;
    end else begin
      len = total + 2;
      put(8'(len >> 8), ST_DATA);
      put(8'(len), ST_DATA);
      for (int i = 0; i < 12; i++) put(pfx[i], ST_DATA);
      kind = KIND_COPY;
    end
  endfunction

  function automatic void clean_step(input logic [7:0] b, input logic eof);
    bit bad;
    logic [15:0] len;
    logic [7:0] hi;
    jms_out_t o;
    bad = 1'b0;
    burst.delete();
    if (ph == P_DONE || ph == P_ERR) return;
    case (ph)
      P_SOI0: if (b == BYTE_FF) ph = P_SOI1; else bad = 1'b1;
      P_SOI1: begin
        if (b == MRK_SOI) begin
          put(BYTE_FF, ST_DATA);
          put(MRK_SOI, ST_DATA);
          ph = P_MARK;
        end else bad = 1'b1;
      end
      P_MARK: begin
        if (b == BYTE_FF) begin
          fills = '0;
          ph = P_FILL;
        end else bad = 1'b1;
      end
      P_FILL, P_SCANFF: begin
        if (b == BYTE_FF) begin
          if (fills >= MaxFill) bad = 1'b1; else fills++;
        end else if (ph == P_SCANFF && (b == 8'h00 || b == MRK_TEM ||
                     (b >= MRK_RST0 && b <= MRK_RST7))) begin
          put_ff_run();
          put(b, ST_DATA);
          ph = P_SCAN;
        end else if (b == 8'h00 || b == MRK_SOI) begin
          bad = 1'b1;
        end else if (b == MRK_EOI) begin
          if (!scan_seen) bad = 1'b1;
          else begin
            put(BYTE_FF, ST_DATA);
            put(MRK_EOI, ST_EOI);
            ph = P_DONE;
          end
        end else if (b == MRK_TEM || (b >= MRK_RST0 && b <= MRK_RST7)) begin
          put_ff_run();
          put(b, ST_DATA);
          ph = P_MARK;
        end else begin
          mark = b;
          ph = P_LENHI;
        end
      end
      P_LENHI: begin
        rem = {8'h00, b};
        ph = P_LENLO;
      end
      P_LENLO: begin
        hi  = rem[7:0];
        len = {hi, b};
        if (len < 16'd2) bad = 1'b1;
        else begin
          rem  = len - 16'd2;
          pcnt = '0;
          if (mark == MRK_APP0) kind = KIND_JFIF;
          else if (mark == MRK_APP14) kind = KIND_ADOBE;
          else if (mark == MRK_APP2 && keep_icc) kind = KIND_ICC;
          else if ((mark >= MRK_APP0 && mark <= MRK_APP15) || mark == MRK_COM)
            kind = KIND_DROP;
          else begin
            kind = KIND_COPY;
            put_ff_run();
            put(mark, ST_DATA);
            put(hi, ST_DATA);
            put(b, ST_DATA);
          end
          ph = P_BODY;
          if (kind >= KIND_JFIF) decide(bad);
          if (!bad && rem == 16'd0) seg_end();
        end
      end
      P_BODY: begin
        rem = rem - 16'd1;
        if (kind == KIND_COPY) put(b, ST_DATA);
        else if (kind >= KIND_JFIF) begin
          if (pcnt < 4'd12) begin
            pfx[pcnt] = b;
            pcnt++;
          end
          decide(bad);
        end
        if (!bad && rem == 16'd0) seg_end();
      end
      P_SCAN: begin
        if (b != BYTE_FF) put(b, ST_DATA);
        else begin
          fills = '0;
          ph = P_SCANFF;
        end
      end
      default: bad = 1'b1;
    endcase
    if (!bad && eof && ph != P_DONE) bad = 1'b1;
    if (bad) begin
      ph = P_ERR;
      burst.delete();
      put(8'h00, ST_ERR);
    end
    if (burst.size() > 0) begin
      o = burst[$];
      o.run_last = 1'b1;
      burst[$] = o;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // monitor and checker
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    jms_out_t exp_b;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      n_in++;
      clean_step(in_data_i.data_byte, in_data_i.end_of_file);
      if (lat_typed) begin
        for (int i = 0; i < lat_n; i++) clean_q.push_back(lat_e[i]);
      end else begin
        foreach (burst[i]) clean_q.push_back(burst[i]);
      end
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_out++;
      if (clean_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h/%0d/%0d", $realtime,
                 out_data_o.out_byte, out_data_o.status, out_data_o.run_last);
        n_bad++;
      end else begin
        exp_b = clean_q.pop_front();
        if (out_data_o.out_byte !== exp_b.out_byte) begin
          $display("%0t: out_byte mismatch, expected %h, actual %h", $realtime,
                   exp_b.out_byte, out_data_o.out_byte);
          n_bad++;
        end
        if (out_data_o.status !== exp_b.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $realtime,
                   exp_b.status, out_data_o.status);
          n_bad++;
        end
        if (out_data_o.run_last !== exp_b.run_last) begin
          $display("%0t: run_last mismatch, expected %0d, actual %0d", $realtime,
                   exp_b.run_last, out_data_o.run_last);
          n_bad++;
        end
      end
    end
  end

  // watchdog: cycles with no beat on either channel
  int quiet;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= WDOG_MAX) begin
      $display("%0t: watchdog expired, %0d beats still owed", $realtime, clean_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_go) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYC) @(negedge clk_i);
        hold_go = 1'b0;
        out_stall_i = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall_i = 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
        out_stall_i = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input logic eof);
    if (!calm && $urandom_range(0, 4) == 0) begin
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 9) - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i = 1'b1;
    in_data_i.data_byte = b;
    in_data_i.end_of_file = eof;
    lat_typed = row_typed;
    lat_n = row_n;
    lat_e = row_e;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    n_sent++;
  endtask

  task automatic drop_valid();
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  // wait for every owed beat, then let the burst queue settle
  task automatic drain();
    drop_valid();
    while (clean_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_icc(input logic v);
    @(negedge clk_i);
    preserve_icc_we_i = 1'b1;
    preserve_icc_i = v;
    keep_icc = v;
    n_cfg++;
    @(negedge clk_i);
    preserve_icc_we_i = 1'b0;
  endtask

  // marker with optional fill bytes, then length and body_q as payload
  task automatic send_segment(input logic [7:0] m, input int nfill);
    int len;
    len = body_q.size() + 2;
    send_byte(BYTE_FF, 1'b0);
    repeat (nfill) send_byte(BYTE_FF, 1'b0);
    send_byte(m, 1'b0);
    send_byte(8'(len >> 8), 1'b0);
    send_byte(8'(len), 1'b0);
    foreach (body_q[i]) send_byte(body_q[i], 1'b0);
  endtask

  task automatic fill_body(input logic [95:0] sig, input int nsig, input int nrand);
    body_q.delete();
    for (int i = 0; i < nsig; i++) body_q.push_back(sig[95-8*i -: 8]);
    repeat (nrand) body_q.push_back(8'($urandom));
  endtask

  task automatic rand_segment();
    int sel, nf;
    logic [7:0] m;
    nf = ($urandom_range(0, 3) == 0) ? $urandom_range(1, MaxFill) : 0;
    sel = $urandom_range(0, 9);
    case (sel)
      0: begin fill_body(SIG_JFIF, 5, $urandom_range(9, 12)); m = MRK_APP0; end
      1: begin fill_body(SIG_JFIF, $urandom_range(0, 4), $urandom_range(0, 4));
         m = MRK_APP0; end
      2: begin fill_body(SIG_ADOBE, 5, $urandom_range(7, 10)); m = MRK_APP14; end
      3: begin fill_body(SIG_ICC, 12, $urandom_range(2, 5)); m = MRK_APP2; end
      4: begin fill_body(SIG_ICC, $urandom_range(0, 11), $urandom_range(0, 3));
         m = MRK_APP2; end
      5: begin fill_body(SIG_ICC, 0, $urandom_range(0, 5));
         m = ($urandom_range(0, 3) == 0) ? MRK_COM : 8'($urandom_range(8'he1, 8'hef));
      end
      6, 7: begin
        fill_body(SIG_ICC, 0, $urandom_range(0, 6));
        case ($urandom_range(0, 3))
          0: m = 8'hc0;
          1: m = 8'hc4;
          2: m = 8'hdb;
          default: m = 8'hdd;
        endcase
      end
      default: begin
        // standalone marker, no length
        send_byte(BYTE_FF, 1'b0);
        repeat (nf) send_byte(BYTE_FF, 1'b0);
        send_byte(($urandom_range(0, 2) == 0) ? MRK_TEM :
                  8'($urandom_range(MRK_RST0, MRK_RST7)), 1'b0);
        return;
      end
    endcase
    send_segment(m, nf);
  endtask

  // entropy-coded bytes with escapes, restart markers and fill runs
  task automatic send_scan_data(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = ($urandom_range(0, 5) == 0) ? BYTE_FF : 8'($urandom);
      send_byte(b, 1'b0);
      if (b == BYTE_FF) begin
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, MaxFill) : 0)
          send_byte(BYTE_FF, 1'b0);
        case ($urandom_range(0, 2))
          0: send_byte(8'h00, 1'b0);
          1: send_byte(MRK_TEM, 1'b0);
          default: send_byte(8'($urandom_range(MRK_RST0, MRK_RST7)), 1'b0);
        endcase
      end
    end
  endtask

  task automatic send_trailer();
    int pick;
    pick = $urandom_range(0, 6);
    case (pick)
      0: begin end_kind = "eoi with end flag";
         send_byte(BYTE_FF, 1'b0); send_byte(MRK_EOI, 1'b1); end
      1: begin end_kind = "eoi then ignored bytes";
         send_byte(BYTE_FF, 1'b0); send_byte(MRK_EOI, 1'b0); end
      2: begin end_kind = "truncated file";
         send_byte(8'($urandom_range(0, 8'hfe)), 1'b1); end
      3: begin end_kind = "too many fill bytes";
         repeat (MaxFill + 2) send_byte(BYTE_FF, 1'b0); end
      4: begin end_kind = "second soi";
         send_byte(BYTE_FF, 1'b0); send_byte(MRK_SOI, 1'b0); end
      5: begin end_kind = "short jfif segment";
         fill_body(SIG_JFIF, 5, 1); send_segment(MRK_APP0, 0); end
      default: begin end_kind = "length below two";
         send_byte(BYTE_FF, 1'b0); send_byte(8'hdb, 1'b0);
         send_byte(8'h00, 1'b0); send_byte(8'h01, 1'b0); end
    endcase
    // everything after the end of the image is dropped without a beat
    repeat (3) send_byte(8'($urandom), 1'b0);
    send_byte(8'($urandom), 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    ph = P_SOI0; fills = '0; mark = '0; rem = '0; kind = KIND_COPY;
    pcnt = '0; scan_seen = 1'b0; keep_icc = 1'b1;
    row_typed = 1'b0; lat_typed = 1'b0; row_n = 0; lat_n = 0;
    row_e = '{NO_BEAT, NO_BEAT}; lat_e = '{NO_BEAT, NO_BEAT};
    calm = 1'b0; hold_go = 1'b0; quiet = 0;
    n_in = 0; n_out = 0; n_bad = 0; n_sent = 0; n_cfg = 0;
    end_kind = "";

    // soi, empty com, copied segment behind fill bytes, tem, adobe too short
    dir_tab = '{
      '{8'hff, 1'b1, 0, NO_BEAT, NO_BEAT},
      '{8'hd8, 1'b1, 2, '{8'hff, ST_DATA, 1'b0}, '{8'hd8, ST_DATA, 1'b1}},
      '{8'hff, 1'b1, 0, NO_BEAT, NO_BEAT},
      '{8'hfe, 1'b1, 0, NO_BEAT, NO_BEAT},
      '{8'h00, 1'b1, 0, NO_BEAT, NO_BEAT},
      '{8'h02, 1'b1, 0, NO_BEAT, NO_BEAT},
      '{8'hff, 1'b0, 0, NO_BEAT, NO_BEAT},
      '{8'hff, 1'b0, 0, NO_BEAT, NO_BEAT},
      '{8'hff, 1'b0, 0, NO_BEAT, NO_BEAT},
      '{8'hdb, 1'b0, 0, NO_BEAT, NO_BEAT},
      '{8'h00, 1'b0, 0, NO_BEAT, NO_BEAT},
      '{8'h03, 1'b0, 0, NO_BEAT, NO_BEAT},
      '{8'h7f, 1'b0, 0, NO_BEAT, NO_BEAT},
      '{8'hff, 1'b0, 0, NO_BEAT, NO_BEAT},
      '{8'h01, 1'b0, 0, NO_BEAT, NO_BEAT},
      '{8'hff, 1'b0, 0, NO_BEAT, NO_BEAT},
      '{8'hee, 1'b0, 0, NO_BEAT, NO_BEAT},
      '{8'h00, 1'b0, 0, NO_BEAT, NO_BEAT},
      '{8'h04, 1'b0, 0, NO_BEAT, NO_BEAT},
      '{8'h41, 1'b0, 0, NO_BEAT, NO_BEAT},
      '{8'h64, 1'b0, 0, NO_BEAT, NO_BEAT}
    };

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // register set to its top value while idle after reset
    write_icc(1'b1);

    foreach (dir_tab[i]) begin
      row_typed = dir_tab[i].typed;
      row_n = dir_tab[i].n;
      row_e[0] = dir_tab[i].e0;
      row_e[1] = dir_tab[i].e1;
      send_byte(dir_tab[i].b, 1'b0);
    end
    row_typed = 1'b0;
    drain();
    write_icc(1'b0);

    // long receiver hold-off while rewritten segments pile up in the queue
    hold_go = 1'b1;
    fill_body(SIG_JFIF, 5, 9);
    send_segment(MRK_APP0, 0);
    fill_body(SIG_ICC, 0, 6);
    send_segment(8'hdb, 3);
    fill_body(SIG_ADOBE, 5, 7);
    send_segment(MRK_APP14, 0);

    // rounds of header segments and scans, register flipped between rounds
    while (n_sent < 110) begin
      repeat ($urandom_range(2, 4)) rand_segment();
      fill_body(SIG_ICC, 0, $urandom_range(1, 4));
      send_segment(MRK_SOS, $urandom_range(0, 2));
      send_scan_data($urandom_range(5, 15));
      if ($urandom_range(0, 1) == 0) begin
        fill_body(SIG_ICC, 0, 2);
        send_segment(MRK_DNL, 0);
        send_scan_data($urandom_range(3, 8));
      end
      drain();
      write_icc(~keep_icc);
    end

    calm = 1'b1;
    send_trailer();
    drop_valid();

    while (clean_q.size() != 0) @(posedge clk_i);
    repeat (2 * DRAIN_CYC) @(posedge clk_i);

    $display("covered %0d input beats, %0d output beats, %0d register writes",
             n_in, n_out, n_cfg);
    $display("file ended by: %s, mismatches: %0d", end_kind, n_bad);
    if (n_bad == 0 && clean_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
